>>> hdl/eml_pkg.sv
// Shared types, constants and helper functions for the executable-mapping
// line classifier. No dependencies; every other file imports this package.
package eml_pkg;

  localparam int LINE_LIMIT = 512;
  localparam int PATH_LIMIT = 255;
  localparam int COL_W      = $clog2(LINE_LIMIT);
  localparam int PLEN_W     = $clog2(PATH_LIMIT + 1);

  localparam int IN_W  = 8;
  localparam int RES_W = 64 + 64 + 32 + 1 + 16;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_LX    = "x";
  localparam logic [7:0] CH_UX    = "X";
  localparam logic [7:0] CH_DASH  = "-";
  localparam logic [7:0] CH_SLASH = "/";

  // excluded path prefixes, left-justified, zero padded
  localparam int EXCL_N   = 7;
  localparam int EXCL_MAX = 10;
  localparam logic [EXCL_MAX*8-1:0] EXCL_PAT [EXCL_N] = '{
    {"[vdso]",    32'h0},
    {"[vvar]",    32'h0},
    {"[vectors]",  8'h0},
    {"[vsyscall]"},
    {"[uprobes]",  8'h0},
    {"[jit]",     40'h0},
    {"[anon:",    32'h0}
  };
  localparam logic [3:0] EXCL_LEN [EXCL_N] = '{
    4'd6, 4'd6, 4'd9, 4'd10, 4'd9, 4'd5, 4'd6
  };

  localparam int MEMFD_LEN = 6;
  localparam logic [MEMFD_LEN*8-1:0] MEMFD_PAT = "memfd:";
  localparam int DEL_LEN = 9;
  localparam logic [DEL_LEN*8-1:0] DEL_PAT = "(deleted)";

  typedef enum logic [16:0] {
    PH_S_PRE    = 17'h00001,
    PH_S_ZERO   = 17'h00002,
    PH_S_DIG    = 17'h00004,
    PH_E_PRE    = 17'h00008,
    PH_E_ZERO   = 17'h00010,
    PH_E_DIG    = 17'h00020,
    PH_P_PRE    = 17'h00040,
    PH_PERM     = 17'h00080,
    PH_K1_PRE   = 17'h00100,
    PH_K1       = 17'h00200,
    PH_K2_PRE   = 17'h00400,
    PH_K2       = 17'h00800,
    PH_K3_PRE   = 17'h01000,
    PH_K3       = 17'h02000,
    PH_PATH_PRE = 17'h04000,
    PH_PATH     = 17'h08000,
    PH_FAIL     = 17'h10000
  } phase_e;

  typedef struct packed {
    logic       clr;
    logic       push;
    logic [7:0] chr;
  } path_ctl_t;

  typedef struct packed {
    logic excluded;
    logic plain_named;   // non-empty path that starts with '/' and has no marker
    logic memfd;
  } path_sts_t;

  typedef struct packed {
    logic [15:0] finding_index;
    logic        is_memfd;
    logic [31:0] perms_text;
    logic [63:0] end_addr;
    logic [63:0] start_addr;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c == 8'd9) || (c == 8'd11) || (c == 8'd12) || (c == 8'd13);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic [7:0] memfd_char(input logic [2:0] i);
    return MEMFD_PAT[8*(MEMFD_LEN-1-int'(i)) +: 8];
  endfunction

  function automatic logic [7:0] del_char(input logic [3:0] i);
    return DEL_PAT[8*(DEL_LEN-1-int'(i)) +: 8];
  endfunction

endpackage

>>> hdl/eml_path_match.sv
// Path tracker: length, leading slash, excluded-prefix survivors and the
// memfd: / (deleted) substring matchers. Depends on eml_pkg.
module eml_path_match
  import eml_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  path_ctl_t ctl_i,
  output path_sts_t sts_o
);

  logic [PLEN_W-1:0] plen_q, plen_d;
  logic              slash_q, slash_d;
  logic [EXCL_N-1:0] alive_q, alive_d;
  logic [2:0]        mprog_q, mprog_d;
  logic              mfound_q, mfound_d;
  logic [3:0]        dprog_q, dprog_d;
  logic              dfound_q, dfound_d;

  logic [3:0]        pos4;
  logic [EXCL_N-1:0] miss;
  logic [EXCL_N-1:0] hit_full;

  assign pos4 = plen_q[3:0];

  always_comb begin
    for (int k = 0; k < EXCL_N; k++) begin
      miss[k] = (plen_q < PLEN_W'(EXCL_LEN[k])) &&
                (EXCL_PAT[k][8*(EXCL_MAX-1-int'(pos4)) +: 8] != ctl_i.chr);
      hit_full[k] = alive_q[k] && (plen_q >= PLEN_W'(EXCL_LEN[k]));
    end
  end

  always_comb begin
    plen_d   = plen_q;
    slash_d  = slash_q;
    alive_d  = alive_q;
    mprog_d  = mprog_q;
    mfound_d = mfound_q;
    dprog_d  = dprog_q;
    dfound_d = dfound_q;
    if (ctl_i.clr) begin
      plen_d   = '0;
      slash_d  = 1'b0;
      alive_d  = '1;
      mprog_d  = '0;
      mfound_d = 1'b0;
      dprog_d  = '0;
      dfound_d = 1'b0;
    end else if (ctl_i.push && (plen_q < PLEN_W'(PATH_LIMIT))) begin
      if (plen_q == '0) begin
        slash_d = (ctl_i.chr == CH_SLASH);
      end
      alive_d = alive_q & ~miss;
      // "mem" is the only self-overlap in memfd:
      if (ctl_i.chr == memfd_char(mprog_q)) begin
        if (mprog_q == 3'(MEMFD_LEN - 1)) begin
          mfound_d = 1'b1;
          mprog_d  = '0;
        end else begin
          mprog_d = mprog_q + 3'd1;
        end
      end else if (mprog_q == 3'd3 && ctl_i.chr == memfd_char(3'd1)) begin
        mprog_d = 3'd2;
      end else if (ctl_i.chr == memfd_char(3'd0)) begin
        mprog_d = 3'd1;
      end else begin
        mprog_d = '0;
      end
      if (ctl_i.chr == del_char(dprog_q)) begin
        if (dprog_q == 4'(DEL_LEN - 1)) begin
          dfound_d = 1'b1;
          dprog_d  = '0;
        end else begin
          dprog_d = dprog_q + 4'd1;
        end
      end else if (ctl_i.chr == del_char(4'd0)) begin
        dprog_d = 4'd1;
      end else begin
        dprog_d = '0;
      end
      plen_d = plen_q + PLEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q   <= '0;
      slash_q  <= 1'b0;
      alive_q  <= '1;
      mprog_q  <= '0;
      mfound_q <= 1'b0;
      dprog_q  <= '0;
      dfound_q <= 1'b0;
    end else begin
      plen_q   <= plen_d;
      slash_q  <= slash_d;
      alive_q  <= alive_d;
      mprog_q  <= mprog_d;
      mfound_q <= mfound_d;
      dprog_q  <= dprog_d;
      dfound_q <= dfound_d;
    end
  end

  assign sts_o.excluded    = |hit_full;
  assign sts_o.plain_named = (plen_q != '0) && slash_q && !mfound_q && !dfound_q;
  assign sts_o.memfd       = mfound_q;

endmodule

>>> hdl/eml_line_parse.sv
// Per-byte line parser: address, permission and field phases, the finding
// counter and the report decision at line end. Depends on eml_pkg, eml_path_match.
module eml_line_parse
  import eml_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] max_findings_i,
  output logic        hit_o,
  output result_t     res_o
);

  phase_e           phase_q, phase_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [63:0]      start_q, start_d;
  logic [63:0]      end_q, end_d;
  logic [31:0]      perm_q, perm_d;
  logic [2:0]       pcnt_q, pcnt_d;
  logic             exec_q, exec_d;
  logic [15:0]      fcnt_q, fcnt_d;

  path_ctl_t path_ctl;
  path_sts_t path_sts;

  logic       ws;
  logic [4:0] hx;
  logic       hv;
  logic [3:0] hval;
  logic       line_end;
  logic       phase_ok;
  logic       report;

  assign ws       = is_ws(byte_i);
  assign hx       = hex_dec(byte_i);
  assign hv       = hx[4];
  assign hval     = hx[3:0];
  assign line_end = (byte_i == CH_NL) || (byte_i == CH_NUL);

  // permission word reached and line not failed
  assign phase_ok = !(phase_q == PH_S_PRE || phase_q == PH_S_ZERO || phase_q == PH_S_DIG ||
                      phase_q == PH_E_PRE || phase_q == PH_E_ZERO || phase_q == PH_E_DIG ||
                      phase_q == PH_P_PRE || phase_q == PH_FAIL);

  assign report = phase_ok && exec_q && !path_sts.excluded && !path_sts.plain_named &&
                  (fcnt_q < max_findings_i);

  eml_path_match u_path (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (path_ctl),
    .sts_o  (path_sts)
  );

  always_comb begin
    phase_d       = phase_q;
    col_d         = col_q;
    start_d       = start_q;
    end_d         = end_q;
    perm_d        = perm_q;
    pcnt_d        = pcnt_q;
    exec_d        = exec_q;
    fcnt_d        = fcnt_q;
    path_ctl.clr  = 1'b0;
    path_ctl.push = 1'b0;
    path_ctl.chr  = byte_i;

    if (step_i && line_end) begin
      phase_d      = PH_S_PRE;
      col_d        = '0;
      start_d      = '0;
      end_d        = '0;
      perm_d       = '0;
      pcnt_d       = '0;
      exec_d       = 1'b0;
      path_ctl.clr = 1'b1;
      if (byte_i == CH_NUL) begin
        fcnt_d = '0;
      end else if (report) begin
        fcnt_d = fcnt_q + 16'd1;
      end
    end else if (step_i && (col_q < COL_W'(LINE_LIMIT - 1))) begin
      col_d = col_q + COL_W'(1);
      unique case (phase_q)
        PH_S_PRE, PH_E_PRE: begin
          if (!ws) begin
            if (!hv) begin
              phase_d = PH_FAIL;
            end else if (phase_q == PH_S_PRE) begin
              start_d = 64'(hval);
              phase_d = (hval == 4'd0) ? PH_S_ZERO : PH_S_DIG;
            end else begin
              end_d   = 64'(hval);
              phase_d = (hval == 4'd0) ? PH_E_ZERO : PH_E_DIG;
            end
          end
        end
        PH_S_ZERO, PH_S_DIG: begin
          if (phase_q == PH_S_ZERO && (byte_i == CH_LX || byte_i == CH_UX)) begin
            phase_d = PH_S_DIG;
          end else if (hv) begin
            start_d = {start_q[59:0], hval};
            phase_d = PH_S_DIG;
          end else if (byte_i == CH_DASH) begin
            phase_d = PH_E_PRE;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_E_ZERO, PH_E_DIG: begin
          if (phase_q == PH_E_ZERO && (byte_i == CH_LX || byte_i == CH_UX)) begin
            phase_d = PH_E_DIG;
          end else if (hv) begin
            end_d   = {end_q[59:0], hval};
            phase_d = PH_E_DIG;
          end else if (ws) begin
            phase_d = PH_P_PRE;
          end else begin
            // non-hex glued to the end address opens the permission word
            perm_d  = {24'd0, byte_i};
            pcnt_d  = 3'd1;
            exec_d  = (byte_i == CH_LX);
            phase_d = PH_PERM;
          end
        end
        PH_P_PRE: begin
          if (!ws) begin
            perm_d  = {24'd0, byte_i};
            pcnt_d  = 3'd1;
            exec_d  = (byte_i == CH_LX);
            phase_d = PH_PERM;
          end
        end
        PH_PERM: begin
          if (ws) begin
            phase_d = PH_K1_PRE;
          end else if (pcnt_q < 3'd7) begin
            if (pcnt_q < 3'd4) begin
              perm_d[{pcnt_q[1:0], 3'b000} +: 8] = byte_i;
            end
            if (byte_i == CH_LX) begin
              exec_d = 1'b1;
            end
            pcnt_d = pcnt_q + 3'd1;
          end else begin
            phase_d = PH_K1;
          end
        end
        PH_K1_PRE: if (!ws) phase_d = PH_K1;
        PH_K1:     if (ws)  phase_d = PH_K2_PRE;
        PH_K2_PRE: if (!ws) phase_d = PH_K2;
        PH_K2:     if (ws)  phase_d = PH_K3_PRE;
        PH_K3_PRE: if (!ws) phase_d = PH_K3;
        PH_K3:     if (ws)  phase_d = PH_PATH_PRE;
        PH_PATH_PRE: begin
          if (!ws) begin
            phase_d       = PH_PATH;
            path_ctl.push = 1'b1;
          end
        end
        PH_PATH: begin
          path_ctl.push = 1'b1;
        end
        PH_FAIL: begin
          phase_d = PH_FAIL;
        end
        default: begin
          phase_d = PH_FAIL;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_S_PRE;
      col_q   <= '0;
      start_q <= '0;
      end_q   <= '0;
      perm_q  <= '0;
      pcnt_q  <= '0;
      exec_q  <= 1'b0;
      fcnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      col_q   <= col_d;
      start_q <= start_d;
      end_q   <= end_d;
      perm_q  <= perm_d;
      pcnt_q  <= pcnt_d;
      exec_q  <= exec_d;
      fcnt_q  <= fcnt_d;
    end
  end

  assign hit_o               = step_i && line_end && report;
  assign res_o.start_addr    = start_q;
  assign res_o.end_addr      = end_q;
  assign res_o.perms_text    = perm_q;
  assign res_o.is_memfd      = path_sts.memfd;
  assign res_o.finding_index = fcnt_q;

endmodule

>>> hdl/exec_mapping_line_classifier.sv
// Top level of the executable-mapping line classifier: input beat register,
// result register, max_findings register. Depends on eml_pkg, eml_line_parse.
//
//  channel   dir  width  contents
//  s_axis    in     8    tdata[7:0] text_byte
//  m_axis    out  184    tdata: start_addr, end_addr, perms_text, is_memfd, finding_index
//  cfg       in    16    max_findings, written when cfg_we_i is high
//
// One byte per cycle while the output is not stalled; a result leaves through the
// input register, then the result register, after the line-end byte is accepted.
// Reset clears all parser state and sets max_findings to 16; no clearing pass.
// An output stall holds the result and one byte in the input register, then
// drops s_axis_tready.
module exec_mapping_line_classifier
  import eml_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // [7:0] text_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [63:0] start_addr, [127:64] end_addr, [159:128] perms_text,
  // [160] is_memfd, [176:161] finding_index, [183:177] zero
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i
);

  logic        in_vld_q, in_vld_d;
  logic [7:0]  in_byte_q;
  logic        out_vld_q, out_vld_d;
  result_t     out_q;
  logic [15:0] max_q, max_d;

  logic    adv;
  logic    hit;
  result_t res;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  eml_line_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (adv),
    .byte_i         (in_byte_q),
    .max_findings_i (max_q),
    .hit_o          (hit),
    .res_o          (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv && hit) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    max_d = cfg_we_i ? cfg_wdata_i : max_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      max_q     <= 16'd16;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      max_q     <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata[7:0];
    end
    if (adv && hit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OUT_W - RES_W)'(0), out_q};

endmodule

>>> hdl/eml_checker.sv
// Port-level checks for exec_mapping_line_classifier, attached by bind.
// Depends on eml_pkg.
module eml_checker
  import eml_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // a free output side never backpressures the input
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("s_axis_tready low while m_axis_tready high");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled result");

  // a fresh result comes from an earlier accepted input beat
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result appeared without a preceding input beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

endmodule

bind exec_mapping_line_classifier eml_checker u_eml_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/tb_exec_mapping_line_classifier.sv
// Self-checking testbench for exec_mapping_line_classifier: feeds map text
// byte by byte and checks findings against a cycle-free line predictor.
// Depends on eml_pkg and the classifier RTL.
`timescale 1ns / 1ps

module tb_exec_mapping_line_classifier;
  import eml_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_we_i      = 1'b0;
  logic [15:0]      cfg_wdata_i   = '0;

  exec_mapping_line_classifier i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Line predictor state
  // ---------------------------------------------------------------------------
  phase_e      phase;
  int          col;
  logic [63:0] start_a, end_a;
  logic [31:0] perm_word;
  int          perm_n;
  logic        x_seen;
  int          path_n;
  logic        slash_first;
  logic [6:0]  excl_alive;
  int          memfd_p, del_p;
  logic        memfd_hit, del_hit;
  logic [15:0] found_n;
  logic [15:0] cap;

  result_t     findings_q[$];
  int          mismatches    = 0;
  int          bytes_sent    = 0;
  int unsigned cycles        = 0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int holdoff_req   = 0;
  int holdoff_left  = 0;

  string hex_set  = "0123456789abcdefABCDEF";
  string perm_set = "rwxps-X";

  function automatic string excl_name(input int k);
    case (k)
      0:       return "[vdso]";
      1:       return "[vvar]";
      2:       return "[vectors]";
      3:       return "[vsyscall]";
      4:       return "[uprobes]";
      5:       return "[jit]";
      default: return "[anon:";
    endcase
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return c == 8'd32 || c == 8'd9 || c == 8'd11 || c == 8'd12 || c == 8'd13;
  endfunction

  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] nib);
    nib = '0;
    if (c >= "0" && c <= "9") begin
      nib = 4'(c - 8'd48);
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      nib = 4'(c - 8'd87);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      nib = 4'(c - 8'd55);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Longest prefix of pat that is a suffix of the text once c is appended.
  function automatic int kmp_step(input string pat, input int prog, input logic [7:0] c);
    int   k;
    logic same;
    if (prog >= pat.len()) prog = pat.len() - 1;
    for (k = prog + 1; k >= 1; k--) begin
      if (pat[k-1] == c) begin
        same = 1'b1;
        for (int j = 0; j < k - 1; j++)
          if (pat[j] != pat[prog-(k-1)+j]) same = 1'b0;
        if (same) return k;
      end
    end
    return 0;
  endfunction

  function automatic void clear_line();
    col         = 0;
    phase       = PH_S_PRE;
    start_a     = '0;
    end_a       = '0;
    perm_word   = '0;
    perm_n      = 0;
    x_seen      = 1'b0;
    path_n      = 0;
    slash_first = 1'b0;
    excl_alive  = '1;
    memfd_p     = 0;
    memfd_hit   = 1'b0;
    del_p       = 0;
    del_hit     = 1'b0;
  endfunction

  function automatic void begin_perm(input logic [7:0] c);
    perm_word = {24'd0, c};
    perm_n    = 1;
    x_seen    = (c == CH_LX);
    phase     = PH_PERM;
  endfunction

  function automatic void path_char(input logic [7:0] c);
    string nm;
    int    p;
    if (path_n >= PATH_LIMIT) return;
    if (path_n == 0) slash_first = (c == CH_SLASH);
    for (int k = 0; k < 7; k++) begin
      nm = excl_name(k);
      if (path_n < nm.len() && nm[path_n] != c) excl_alive[k] = 1'b0;
    end
    p = kmp_step("memfd:", memfd_p, c);
    if (p >= 6) begin
      memfd_hit = 1'b1;
      p = 0;
    end
    memfd_p = p;
    p = kmp_step("(deleted)", del_p, c);
    if (p >= 9) begin
      del_hit = 1'b1;
      p = 0;
    end
    del_p  = p;
    path_n = path_n + 1;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    logic       ws, dig;
    logic [3:0] nib;
    ws  = blank(c);
    dig = hex_nibble(c, nib);
    case (phase)
      PH_S_PRE, PH_E_PRE: begin
        if (!ws) begin
          if (!dig) begin
            phase = PH_FAIL;
          end else if (phase == PH_S_PRE) begin
            start_a = {60'd0, nib};
            phase   = (nib == 0) ? PH_S_ZERO : PH_S_DIG;
          end else begin
            end_a = {60'd0, nib};
            phase = (nib == 0) ? PH_E_ZERO : PH_E_DIG;
          end
        end
      end
      PH_S_ZERO, PH_S_DIG: begin
        if (phase == PH_S_ZERO && (c == CH_LX || c == CH_UX)) begin
          phase = PH_S_DIG;
        end else if (dig) begin
          start_a = {start_a[59:0], nib};
          phase   = PH_S_DIG;
        end else if (c == CH_DASH) begin
          phase = PH_E_PRE;
        end else begin
          phase = PH_FAIL;
        end
      end
      PH_E_ZERO, PH_E_DIG: begin
        if (phase == PH_E_ZERO && (c == CH_LX || c == CH_UX)) begin
          phase = PH_E_DIG;
        end else if (dig) begin
          end_a = {end_a[59:0], nib};
          phase = PH_E_DIG;
        end else if (ws) begin
          phase = PH_P_PRE;
        end else begin
          begin_perm(c);
        end
      end
      PH_P_PRE: if (!ws) begin_perm(c);
      PH_PERM: begin
        if (ws) begin
          phase = PH_K1_PRE;
        end else if (perm_n < 7) begin
          if (perm_n < 4) perm_word[8*perm_n +: 8] = c;
          if (c == CH_LX) x_seen = 1'b1;
          perm_n = perm_n + 1;
        end else begin
          phase = PH_K1;
        end
      end
      PH_K1_PRE: if (!ws) phase = PH_K1;
      PH_K1:     if (ws) phase = PH_K2_PRE;
      PH_K2_PRE: if (!ws) phase = PH_K2;
      PH_K2:     if (ws) phase = PH_K3_PRE;
      PH_K3_PRE: if (!ws) phase = PH_K3;
      PH_K3:     if (ws) phase = PH_PATH_PRE;
      PH_PATH_PRE: begin
        if (!ws) begin
          phase = PH_PATH;
          path_char(c);
        end
      end
      PH_PATH: path_char(c);
      default: ;
    endcase
  endfunction

  function automatic logic line_reportable(output result_t f);
    logic  excl;
    string nm;
    f    = '0;
    excl = 1'b0;
    // one-hot phase codes keep the parse order
    if (phase < PH_PERM || phase == PH_FAIL) return 1'b0;
    for (int k = 0; k < 7; k++) begin
      nm = excl_name(k);
      if (excl_alive[k] && path_n >= nm.len()) excl = 1'b1;
    end
    if (!x_seen || excl) return 1'b0;
    if (path_n > 0 && slash_first && !memfd_hit && !del_hit) return 1'b0;
    if (found_n >= cap) return 1'b0;
    f.start_addr    = start_a;
    f.end_addr      = end_a;
    f.perms_text    = perm_word;
    f.is_memfd      = memfd_hit;
    f.finding_index = found_n;
    found_n         = found_n + 1;
    return 1'b1;
  endfunction

  function automatic void classify_byte(input logic [7:0] c);
    result_t f;
    if (c == CH_NL || c == CH_NUL) begin
      if (line_reportable(f)) findings_q.push_back(f);
      if (c == CH_NUL) found_n = '0;
      clear_line();
    end else if (col < LINE_LIMIT - 1) begin
      col = col + 1;
      parse_char(c);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking, receiver, watchdog
  // ---------------------------------------------------------------------------
  function automatic void flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, what);
  endfunction

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[RES_W-1:0]);
      if (findings_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected finding start=%h end=%h",
                                got.start_addr, got.end_addr));
      end else begin
        want = findings_q.pop_front();
        if (got.start_addr !== want.start_addr)
          flag_mismatch($sformatf("start_addr expected %h, got %h",
                                  want.start_addr, got.start_addr));
        if (got.end_addr !== want.end_addr)
          flag_mismatch($sformatf("end_addr expected %h, got %h",
                                  want.end_addr, got.end_addr));
        if (got.perms_text !== want.perms_text)
          flag_mismatch($sformatf("perms_text expected %h, got %h",
                                  want.perms_text, got.perms_text));
        if (got.is_memfd !== want.is_memfd)
          flag_mismatch($sformatf("is_memfd expected %b, got %b",
                                  want.is_memfd, got.is_memfd));
        if (got.finding_index !== want.finding_index)
          flag_mismatch($sformatf("finding_index expected %0d, got %0d",
                                  want.finding_index, got.finding_index));
      end
    end
  end

  always @(negedge clk_i) begin
    if (holdoff_req > 0) begin
      holdoff_left = holdoff_req;
      holdoff_req  = 0;
    end
    if (holdoff_left > 0) begin
      m_axis_tready = 1'b0;
      holdoff_left--;
    end else begin
      m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("exec_mapping_line_classifier regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    classify_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Register writes only with nothing in flight; the extra cycles cover a
  // line end that produced no finding.
  task automatic set_cap(input logic [15:0] v);
    s_axis_tvalid = 1'b0;
    while (findings_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    cfg_wdata_i = v;
    cfg_we_i    = 1'b1;
    @(posedge clk_i);
    cap = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random text generation
  // ---------------------------------------------------------------------------
  function automatic string ws_text();
    case ($urandom_range(0, 9))
      0:       return "\t";
      1:       return $sformatf("%c", 8'd11);
      2:       return $sformatf("%c", 8'd12);
      3:       return "\r";
      4:       return "  ";
      default: return " ";
    endcase
  endfunction

  function automatic string addr_text();
    string s;
    int    n;
    s = "";
    case ($urandom_range(0, 39))
      0:       s = "+";
      1:       s = "-";
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) s = {s, ($urandom_range(0, 1) ? "0x" : "0X")};
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 12);
    repeat (n) s = {s, $sformatf("%c", hex_set[$urandom_range(0, 21)])};
    return s;
  endfunction

  function automatic string perm_text();
    string s;
    int    n;
    s = "";
    case ($urandom_range(0, 7))
      0: s = "r-xp";
      1: s = "rwxp";
      2: s = "r--p";
      3: s = "--xs";
      4: s = "x";
      default: begin
        n = $urandom_range(1, 9);
        repeat (n) s = {s, $sformatf("%c", perm_set[$urandom_range(0, 6)])};
      end
    endcase
    return s;
  endfunction

  function automatic string field_text();
    case ($urandom_range(0, 5))
      0:       return "00000000";
      1:       return "0";
      2:       return "fd:01";
      3:       return "08:03";
      4:       return "1234567";
      default: return "-";
    endcase
  endfunction

  function automatic string path_frag();
    case ($urandom_range(0, 14))
      0:       return "/";
      1:       return "mem";
      2:       return "memfd:";
      3:       return "mmemfd";
      4:       return "(del";
      5:       return "(deleted)";
      6:       return "((deleted";
      7:       return "eted)";
      8:       return "[v";
      9:       return "[vdso";
      10:      return "dso]";
      11:      return " ";
      12:      return "\t";
      13:      return "lib";
      default: return "x";
    endcase
  endfunction

  function automatic string path_text();
    string s;
    int    n;
    s = "";
    case ($urandom_range(0, 15))
      0, 1: s = "";
      2:    s = "/usr/lib/libc.so.6";
      3:    s = "/memfd:dex (deleted)";
      4:    s = "/dev/shm/buf (deleted)";
      5:    s = excl_name($urandom_range(0, 6));
      6:    s = "[anon:scudo]";
      7:    s = "[heap]";
      8:    s = "[stack]";
      9:    s = "memfd:x";
      10:   s = "/system/bin/app_process64";
      11: begin
        if ($urandom_range(0, 3) == 0) begin
          // straddles the path limit
          n = $urandom_range(240, 300);
          s = "/";
          repeat (n) s = {s, "b"};
          s = {s, "memfd:"};
        end else begin
          s = "/x";
        end
      end
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) s = {s, path_frag()};
      end
    endcase
    return s;
  endfunction

  task automatic send_random_line();
    string ln;
    int    n, cut;
    if ($urandom_range(0, 99) < 8) begin
      n = $urandom_range(1, 24);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      send_byte(CH_NL);
    end else begin
      ln = addr_text();
      ln = {ln, ($urandom_range(0, 19) == 0) ? "_" : "-", addr_text()};
      if ($urandom_range(0, 9) == 0) ln = {ln, perm_text()};
      else ln = {ln, ws_text(), perm_text()};
      ln = {ln, ws_text(), field_text(), ws_text(), field_text(), ws_text(), field_text()};
      if ($urandom_range(0, 4) != 0) ln = {ln, ws_text(), path_text()};
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(0, ln.len());
        ln  = (cut == 0) ? "" : ln.substr(0, cut - 1);
      end
      send_text(ln);
      send_byte(($urandom_range(0, 11) == 0) ? CH_NUL : CH_NL);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_address_forms();
    set_cap(16'd16);
    send_text("0x7f00-0X7f10 r-xp 00000000 08:01 123\n");
    send_text("FFFFFFFFFFFFFFFF-0 --x- 0 0 0\n");
    send_text("123456789abcdef0123-fedcba9876543210F x 0 0 0\n");  // wraps
    send_text("0x-0X x 0 0 0\n");
    send_text("-1-2 r-xp 0 0 0\n");
    send_text("+1-2 r-xp 0 0 0\n");
    send_text("12_34 r-xp 0 0 0\n");
    send_text("1- r-xp 0 0 0\n");
    send_text("\t 1-2r-xp 0 0 0\n");
    send_text("1-2 r--psQZx 0 0 []\n");   // eighth perm char not counted
    send_text("1-2 rwxpsQZZZ 0 0 0 /bin\n");
    send_text("1-2\n");
    send_text("1-2 x\n");
  endtask

  task automatic test_path_rules();
    send_text("1-2 r-xp 0 0 0 /usr/lib/libc.so\n");
    send_text("3-4 r-xp 0 0 0  \t/memfd:jit-cache (deleted)\n");
    send_text("5-6 r-xp 0 0 0 /tmp/x (deleted)\n");
    send_text("7-8 r-xp 0 0 0 /mmemfd:x\n");
    send_text("9-a r-xp 0 0 0 /a ((deleted)\n");
    for (int k = 0; k < 7; k++) send_text({"b-c r-xp 0 0 0 ", excl_name(k), "x\n"});
    send_text("d-e r-xp 0 0 0 [vds\n");
    send_text("d-e r-xp 0 0 0 [heap]\n");
    send_text("f-10 r--p 0 0 0\n");
    send_text("zz-1 r-xp 0 0 0\n");
    send_text("11-12 r-xp 0 0 0 ");
    send_byte(8'h80);
    send_byte(8'hff);
    send_byte(CH_NL);
    send_text("13-14 x 0 0 0 /a/b");
    send_byte(CH_NUL);
    send_text("15-16 x 0 0 0");
    send_byte(CH_NUL);
  endtask

  task automatic test_line_limits();
    string s;
    // memfd: lands past the path limit
    s = "1-2 x 0 0 0 /";
    repeat (260) s = {s, "a"};
    send_text({s, "memfd:\n"});
    // path starts past the line limit
    s = "3-4 x 0 0 0 ";
    repeat (500) s = {s, " "};
    send_text({s, "/lib.so\n"});
  endtask

  task automatic test_finding_cap();
    set_cap(16'd0);
    for (int i = 0; i < 3; i++) send_text($sformatf("%0h-%0h r-xp 0 0 0\n", i, i + 1));
    set_cap(16'd1);
    for (int i = 0; i < 3; i++) send_text($sformatf("%0h-%0h r-xp 0 0 0\n", i, i + 1));
    send_byte(CH_NUL);
    for (int i = 0; i < 2; i++) send_text($sformatf("%0h-%0h --xp 0 0 0\n", i, i + 1));
    send_byte(CH_NUL);
  endtask

  task automatic test_backpressure();
    set_cap(16'hffff);
    send_idle_pct = 0;
    stall_pct     = 0;
    holdoff_req   = 300;
    for (int i = 0; i < 8; i++) send_text($sformatf("%0h-%0h x 0 0 0\n", i, i + 2));
    send_byte(CH_NUL);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall,
                                     input logic [15:0] cap_v, input int n_bytes);
    int b0;
    set_cap(cap_v);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    b0 = bytes_sent;
    while (bytes_sent - b0 < n_bytes) send_random_line();
  endtask

  initial begin
    cap     = 16'd16;
    found_n = '0;
    clear_line();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_address_forms();
    test_path_rules();
    test_line_limits();
    test_finding_cap();
    test_backpressure();
    test_random_traffic(0, 0, 16'hffff, 70);
    test_random_traffic(74, 0, 16'($urandom_range(2, 20)), 70);
    test_random_traffic(0, 74, 16'd16, 70);
    test_random_traffic(38, 38, 16'hffff, 70);

    s_axis_tvalid = 1'b0;
    while (findings_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && findings_q.size() == 0) begin
      $display("exec_mapping_line_classifier regression: pass");
    end else begin
      $display("exec_mapping_line_classifier regression: fail");
    end
    $finish;
  end

endmodule
